// ===== rtl/core/macr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macr_pkg
// Shared types and constants for the moving average change reporter.
// ----------------------------------------------------------------------------
package macr_pkg;

    localparam int SAMPLE_W = 12;
    localparam int MEAN_W   = 12;
    localparam int DELTA_W  = 12;
    localparam int PERIOD_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 1'b1;

    localparam logic [DELTA_W-1:0]  MIN_DELTA_RST = 12'd5;
    localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd1000;
    localparam logic [PERIOD_W-1:0] MS_MAX        = 16'hFFFF;

    // Per-request control travelling alongside the data path
    typedef struct packed {
        logic tick;
        logic link;
        logic result;
    } t_item_ctl;

endpackage

// ===== rtl/core/moving_average_change_reporter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_change_reporter
// A sample's result passes the ring register, the mean stages and the result register before it is valid.
// Throughput: one request per cycle while the output is not stalled, set by the single ring read/write port.
// Reset: clears pointer, fill flag, sum, last value, tick counter and
// result valid; min_delta = 5, publish_period_ms = 1000. Ring not cleared.
// ----------------------------------------------------------------------------
module moving_average_change_reporter #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_command,
    input  logic [macr_pkg::SAMPLE_W-1:0]   i_sample_value,
    input  logic                            i_link_up,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [macr_pkg::MEAN_W-1:0]     o_mean_value,
    output logic                            o_publish,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [macr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [macr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import macr_pkg::*;

    logic                   w_r_valid, w_r_ready;
    t_item_ctl              w_r_ctl;
    logic [SAMPLE_BITS-1:0] w_r_sample, w_r_old;
    logic                   w_m_valid, w_m_ready;
    t_item_ctl              w_m_ctl;
    logic [SAMPLE_BITS-1:0] w_m_mean;

    assign o_cfg_ready = 1'b1;

    macr_ring #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_sample_value (i_sample_value),
        .i_link_up      (i_link_up),
        .o_valid        (w_r_valid),
        .i_ready        (w_r_ready),
        .o_ctl          (w_r_ctl),
        .o_sample       (w_r_sample),
        .o_old          (w_r_old)
    );

    macr_mean #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mean (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_r_valid),
        .o_ready  (w_r_ready),
        .i_ctl    (w_r_ctl),
        .i_sample (w_r_sample),
        .i_old    (w_r_old),
        .o_valid  (w_m_valid),
        .i_ready  (w_m_ready),
        .o_ctl    (w_m_ctl),
        .o_mean   (w_m_mean)
    );

    macr_decide #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_m_valid),
        .o_ready      (w_m_ready),
        .i_ctl        (w_m_ctl),
        .i_mean       (w_m_mean),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_mean_value (o_mean_value),
        .o_publish    (o_publish)
    );

endmodule

// ===== rtl/core/macr_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macr_ring
// Sample ring memory with write pointer and fill flag. Reads the replaced
// entry and writes the new sample in the same cycle (read-first).
// ----------------------------------------------------------------------------
module macr_ring #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_command,
    input  logic [macr_pkg::SAMPLE_W-1:0]   i_sample_value,
    input  logic                            i_link_up,
    output logic                            o_valid,
    input  logic                            i_ready,
    output macr_pkg::t_item_ctl             o_ctl,
    output logic [SAMPLE_BITS-1:0]          o_sample,
    output logic [SAMPLE_BITS-1:0]          o_old
);
    import macr_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    logic [SAMPLE_BITS-1:0] r_ring [WINDOW];

    logic [SLOT_W-1:0]      r_slot;
    logic                   r_full;
    logic                   r_v1;
    t_item_ctl              r_ctl1;
    logic [SAMPLE_BITS-1:0] r_sample1;
    logic [SAMPLE_BITS-1:0] r_old1;
    logic                   r_full1;

    logic                   w_take;
    logic                   w_take_sample;
    logic                   w_wrap;
    logic [SAMPLE_BITS-1:0] w_sample;

    assign o_in_ready    = !r_v1 || i_ready;
    assign w_take        = i_in_valid && o_in_ready;
    assign w_take_sample = w_take && !i_command;
    assign w_wrap        = (r_slot == LAST_SLOT);
    assign w_sample      = SAMPLE_BITS'(i_sample_value);

    always_ff @(posedge i_clk) begin
        if (w_take_sample) begin
            r_old1         <= r_ring[r_slot];
            r_ring[r_slot] <= w_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_full <= 1'b0;
            r_v1   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_v1 <= i_in_valid;
            end
            if (w_take_sample) begin
                r_slot <= w_wrap ? '0 : r_slot + 1'b1;
                if (w_wrap) begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ctl1.tick   <= i_command;
            r_ctl1.link   <= i_link_up;
            r_ctl1.result <= !i_command && (r_full || w_wrap);
            r_sample1     <= w_sample;
            r_full1       <= r_full;
        end
    end

    assign o_valid  = r_v1;
    assign o_ctl    = r_ctl1;
    assign o_sample = r_sample1;
    assign o_old    = r_full1 ? r_old1 : '0;

endmodule

// ===== rtl/core/macr_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macr_mean
// Running sum update and floor division by the window length: reciprocal
// multiply, then a single remainder correction.
// ----------------------------------------------------------------------------
module macr_mean #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  macr_pkg::t_item_ctl         i_ctl,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    input  logic [SAMPLE_BITS-1:0]      i_old,
    output logic                        o_valid,
    input  logic                        i_ready,
    output macr_pkg::t_item_ctl         o_ctl,
    output logic [SAMPLE_BITS-1:0]      o_mean
);
    import macr_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam logic [SUM_W:0]   RECIP = (SUM_W + 1)'((64'd1 << SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);

    logic                   r_v2, r_v3, r_v4;
    t_item_ctl              r_ctl2, r_ctl3, r_ctl4;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       r_sum3;
    logic [PROD_W-1:0]      r_prod;
    logic [SAMPLE_BITS-1:0] r_mean;

    logic                   w_ld2, w_ld3, w_ld4;
    logic [PROD_W-1:0]      w_prod;
    logic [SAMPLE_BITS-1:0] w_q0;
    logic [SUM_W-1:0]       w_rem;

    assign w_ld4   = !r_v4 || i_ready;
    assign w_ld3   = !r_v3 || w_ld4;
    assign w_ld2   = !r_v2 || w_ld3;
    assign o_ready = w_ld2;

    assign w_prod = PROD_W'(r_sum) * PROD_W'(RECIP);
    assign w_q0   = r_prod[SUM_W +: SAMPLE_BITS];
    assign w_rem  = r_sum3 - SUM_W'(w_q0) * WIN_S;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_sum <= '0;
        end else begin
            if (w_ld2) begin
                r_v2 <= i_valid;
                if (i_valid && !i_ctl.tick) begin
                    r_sum <= r_sum - SUM_W'(i_old) + SUM_W'(i_sample);
                end
            end
            if (w_ld3) begin
                r_v3 <= r_v2;
            end
            if (w_ld4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_ctl2 <= i_ctl;
        end
        if (w_ld3) begin
            r_ctl3 <= r_ctl2;
            r_prod <= w_prod;
            r_sum3 <= r_sum;
        end
        if (w_ld4) begin
            r_ctl4 <= r_ctl3;
            r_mean <= (w_rem >= WIN_S) ? w_q0 + 1'b1 : w_q0;
        end
    end

    assign o_valid = r_v4;
    assign o_ctl   = r_ctl4;
    assign o_mean  = r_mean;

endmodule

// ===== rtl/core/macr_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macr_decide
// Deadband and period check, tick counter, last published value,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module macr_decide #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  macr_pkg::t_item_ctl             i_ctl,
    input  logic [SAMPLE_BITS-1:0]          i_mean,
    input  logic                            i_cfg_valid,
    input  logic [macr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [macr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [macr_pkg::MEAN_W-1:0]     o_mean_value,
    output logic                            o_publish
);
    import macr_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > DELTA_W) ? SAMPLE_BITS : DELTA_W;

    logic [DELTA_W-1:0]     r_min_delta;
    logic [PERIOD_W-1:0]    r_period;
    logic [PERIOD_W-1:0]    r_ms;
    logic [SAMPLE_BITS-1:0] r_last;
    logic                   r_out_valid;
    logic [MEAN_W-1:0]      r_mean_out;
    logic                   r_pub;

    logic                   w_take;
    logic [SAMPLE_BITS-1:0] w_diff;
    logic                   w_pub;

    assign o_ready = !i_ctl.result || !r_out_valid || i_out_ready;
    assign w_take  = i_valid && o_ready;
    assign w_diff  = (i_mean >= r_last) ? i_mean - r_last : r_last - i_mean;
    assign w_pub   = (CMP_W'(w_diff) > CMP_W'(r_min_delta)) && (r_ms >= r_period)
                     && i_ctl.link;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_delta <= MIN_DELTA_RST;
            r_period    <= PERIOD_RST;
            r_ms        <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MIN_DELTA: r_min_delta <= i_cfg_data[DELTA_W-1:0];
                    CFG_PERIOD:    r_period    <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (w_take && i_ctl.result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_take) begin
                if (i_ctl.tick) begin
                    if (r_ms != MS_MAX) begin
                        r_ms <= r_ms + 1'b1;
                    end
                end else if (i_ctl.result && w_pub) begin
                    r_last <= i_mean;
                    r_ms   <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_ctl.result) begin
            r_mean_out <= MEAN_W'(i_mean);
            r_pub      <= w_pub;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mean_value = r_mean_out;
    assign o_publish    = r_pub;

endmodule
